@@ rtl/core/sm83alu_pkg.sv @@
// Shared types and operation codes for the SM83 ALU and flag unit.
// Used by the channel interfaces, the compute core and the top level.
package sm83alu_pkg;

  localparam int unsigned FuncWidth = 6;
  localparam int unsigned DataWidth = 16;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned BitIdxWidth = 3;

  typedef logic [FuncWidth-1:0] func_t;

  localparam func_t OP_ADD8  = 6'd0;
  localparam func_t OP_ADC8  = 6'd1;
  localparam func_t OP_SUB8  = 6'd2;
  localparam func_t OP_SBC8  = 6'd3;
  localparam func_t OP_INC8  = 6'd4;
  localparam func_t OP_DEC8  = 6'd5;
  localparam func_t OP_AND8  = 6'd6;
  localparam func_t OP_OR8   = 6'd7;
  localparam func_t OP_XOR8  = 6'd8;
  localparam func_t OP_CP8   = 6'd9;
  localparam func_t OP_ADD16 = 6'd10;
  localparam func_t OP_INC16 = 6'd11;
  localparam func_t OP_DEC16 = 6'd12;
  localparam func_t OP_ADDSP = 6'd13;
  localparam func_t OP_RLCA  = 6'd14;
  localparam func_t OP_RRCA  = 6'd15;
  localparam func_t OP_RLA   = 6'd16;
  localparam func_t OP_RRA   = 6'd17;
  localparam func_t OP_RLC   = 6'd18;
  localparam func_t OP_RRC   = 6'd19;
  localparam func_t OP_RL    = 6'd20;
  localparam func_t OP_RR    = 6'd21;
  localparam func_t OP_SLA   = 6'd22;
  localparam func_t OP_SRA   = 6'd23;
  localparam func_t OP_SRL   = 6'd24;
  localparam func_t OP_SWAP  = 6'd25;
  localparam func_t OP_BIT   = 6'd26;
  localparam func_t OP_RES   = 6'd27;
  localparam func_t OP_SET   = 6'd28;
  localparam func_t OP_DAA   = 6'd29;
  localparam func_t OP_CPL   = 6'd30;
  localparam func_t OP_CCF   = 6'd31;
  localparam func_t OP_SCF   = 6'd32;

  localparam logic [3:0]  NibbleMax    = 4'h9;
  localparam logic [8:0]  DaaHighLimit = 9'h09F;
  localparam logic [8:0]  DaaLowAdj    = 9'h006;
  localparam logic [8:0]  DaaHighAdj   = 9'h060;

  typedef struct packed {
    func_t                  func;
    logic [DataWidth-1:0]   first_value;
    logic [DataWidth-1:0]   second_value;
    logic [BitIdxWidth-1:0] bit_number;
    logic                   zero_in;
    logic                   subtract_in;
    logic                   half_in;
    logic                   carry_in;
  } alu_req_t;

  typedef struct packed {
    logic [DataWidth-1:0] value_out;
    logic                 zero_out;
    logic                 subtract_out;
    logic                 half_out;
    logic                 carry_out;
  } alu_rsp_t;

endpackage

@@ rtl/core/sm83alu_if.sv @@
// Valid/ready channel interfaces for the SM83 ALU request and response words.
// Depends on sm83alu_pkg for the field widths.
interface sm83alu_in_if;
  logic                                    valid;
  logic                                    ready;
  sm83alu_pkg::func_t                      func;
  logic [sm83alu_pkg::DataWidth-1:0]       first_value;
  logic [sm83alu_pkg::DataWidth-1:0]       second_value;
  logic [sm83alu_pkg::BitIdxWidth-1:0]     bit_number;
  logic                                    zero_in;
  logic                                    subtract_in;
  logic                                    half_in;
  logic                                    carry_in;

  modport source (
    output valid, func, first_value, second_value, bit_number,
           zero_in, subtract_in, half_in, carry_in,
    input  ready
  );
  modport sink (
    input  valid, func, first_value, second_value, bit_number,
           zero_in, subtract_in, half_in, carry_in,
    output ready
  );
endinterface

interface sm83alu_out_if;
  logic                              valid;
  logic                              ready;
  logic [sm83alu_pkg::DataWidth-1:0] value_out;
  logic                              zero_out;
  logic                              subtract_out;
  logic                              half_out;
  logic                              carry_out;

  modport source (
    output valid, value_out, zero_out, subtract_out, half_out, carry_out,
    input  ready
  );
  modport sink (
    input  valid, value_out, zero_out, subtract_out, half_out, carry_out,
    output ready
  );
endinterface

@@ rtl/core/sm83_alu_flags_unit.sv @@
// SM83 ALU and flag unit top level: request register, datapath, response register.
// An accepted request word is held in the request register, and its response word in the response register.
// Throughput is one word per cycle; both stages advance together while the output drains.
// A stalled response holds in the output register; the request stage can still fill but then holds.
// Reset (rst_n low, synchronous) empties both stages; payload registers are not reset.
// Depends on sm83alu_pkg, sm83alu_if and sm83alu_core.
module sm83_alu_flags_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  sm83alu_in_if.sink           in_ch,
  sm83alu_out_if.source        out_ch
);

  logic                  req_valid_r;
  sm83alu_pkg::alu_req_t req_r;
  logic                  rsp_valid_r;
  sm83alu_pkg::alu_rsp_t rsp_r;
  sm83alu_pkg::alu_rsp_t rsp_nxt;
  logic                  rsp_adv;
  logic                  in_take;

  assign rsp_adv     = !rsp_valid_r || out_ch.ready;
  assign in_ch.ready = !req_valid_r || rsp_adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  sm83alu_core u_core (
    .req (req_r),
    .rsp (rsp_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      rsp_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        req_valid_r <= in_ch.valid;
      end
      if (rsp_adv) begin
        rsp_valid_r <= req_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r.func         <= in_ch.func;
      req_r.first_value  <= in_ch.first_value;
      req_r.second_value <= in_ch.second_value;
      req_r.bit_number   <= in_ch.bit_number;
      req_r.zero_in      <= in_ch.zero_in;
      req_r.subtract_in  <= in_ch.subtract_in;
      req_r.half_in      <= in_ch.half_in;
      req_r.carry_in     <= in_ch.carry_in;
    end
    if (rsp_adv && req_valid_r) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_ch.valid        = rsp_valid_r;
  assign out_ch.value_out    = rsp_r.value_out;
  assign out_ch.zero_out     = rsp_r.zero_out;
  assign out_ch.subtract_out = rsp_r.subtract_out;
  assign out_ch.half_out     = rsp_r.half_out;
  assign out_ch.carry_out    = rsp_r.carry_out;

endmodule

@@ rtl/core/sm83alu_core.sv @@
// Combinational SM83 ALU datapath: result value and new flags for one request word.
// Depends on sm83alu_pkg for operation codes and the request/response structs.
module sm83alu_core (
  input  sm83alu_pkg::alu_req_t req,
  output sm83alu_pkg::alu_rsp_t rsp
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic [15:0] x;
  logic [15:0] y;
  logic        cin;
  logic        use_c;
  logic [8:0]  add9;
  logic [4:0]  addh5;
  logic [8:0]  sub9;
  logic [4:0]  subh5;
  logic [16:0] add17;
  logic [12:0] addh13;
  logic [8:0]  spc9;
  logic [4:0]  sph5;
  logic [15:0] sp_sum;
  logic [7:0]  bit_mask;
  logic [8:0]  daa_lo;
  logic [8:0]  daa_hi;
  logic [7:0]  daa_s1;
  logic [7:0]  daa_s2;
  logic [7:0]  r8;

  assign a   = req.first_value[7:0];
  assign b   = req.second_value[7:0];
  assign x   = req.first_value;
  assign y   = req.second_value;
  assign cin = req.carry_in;

  assign use_c  = cin & ((req.func == sm83alu_pkg::OP_ADC8) ||
                         (req.func == sm83alu_pkg::OP_SBC8));
  assign add9   = {1'b0, a} + {1'b0, b} + {8'b0, use_c};
  assign addh5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, use_c};
  assign sub9   = {1'b0, a} - {1'b0, b} - {8'b0, use_c};
  assign subh5  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, use_c};
  assign add17  = {1'b0, x} + {1'b0, y};
  assign addh13 = {1'b0, x[11:0]} + {1'b0, y[11:0]};
  assign spc9   = {1'b0, x[7:0]} + {1'b0, b};
  assign sph5   = {1'b0, x[3:0]} + {1'b0, b[3:0]};
  assign sp_sum = x + {{8{b[7]}}, b};
  assign bit_mask = 8'b1 << req.bit_number;

  // Decimal adjust: add mode corrects the low then the high digit on the
  // running 9-bit value, subtract mode only follows the incoming H and C.
  always_comb begin
    daa_lo = {1'b0, a};
    if (req.half_in || (a[3:0] > sm83alu_pkg::NibbleMax)) begin
      daa_lo = {1'b0, a} + sm83alu_pkg::DaaLowAdj;
    end
    daa_hi = daa_lo;
    if (cin || (daa_lo > sm83alu_pkg::DaaHighLimit)) begin
      daa_hi = daa_lo + sm83alu_pkg::DaaHighAdj;
    end
    daa_s1 = req.half_in ? (a - sm83alu_pkg::DaaLowAdj[7:0]) : a;
    daa_s2 = cin ? (daa_s1 - sm83alu_pkg::DaaHighAdj[7:0]) : daa_s1;
  end

  always_comb begin
    rsp.value_out    = x;
    rsp.zero_out     = req.zero_in;
    rsp.subtract_out = req.subtract_in;
    rsp.half_out     = req.half_in;
    rsp.carry_out    = cin;
    r8               = 8'h00;
    unique case (req.func)
      sm83alu_pkg::OP_ADD8, sm83alu_pkg::OP_ADC8: begin
        r8 = add9[7:0];
        rsp.value_out = {8'h00, r8};
        rsp.zero_out = (r8 == 8'h00);
        rsp.subtract_out = 1'b0;
        rsp.half_out = addh5[4];
        rsp.carry_out = add9[8];
      end
      sm83alu_pkg::OP_SUB8, sm83alu_pkg::OP_SBC8: begin
        r8 = sub9[7:0];
        rsp.value_out = {8'h00, r8};
        rsp.zero_out = (r8 == 8'h00);
        rsp.subtract_out = 1'b1;
        rsp.half_out = subh5[4];
        rsp.carry_out = sub9[8];
      end
      sm83alu_pkg::OP_CP8: begin
        rsp.zero_out = (sub9[7:0] == 8'h00);
        rsp.subtract_out = 1'b1;
        rsp.half_out = subh5[4];
        rsp.carry_out = sub9[8];
      end
      sm83alu_pkg::OP_INC8: begin
        r8 = a + 8'd1;
        rsp.value_out = {8'h00, r8};
        rsp.zero_out = (r8 == 8'h00);
        rsp.subtract_out = 1'b0;
        rsp.half_out = (a[3:0] == 4'hF);
      end
      sm83alu_pkg::OP_DEC8: begin
        r8 = a - 8'd1;
        rsp.value_out = {8'h00, r8};
        rsp.zero_out = (r8 == 8'h00);
        rsp.subtract_out = 1'b1;
        rsp.half_out = (a[3:0] == 4'h0);
      end
      sm83alu_pkg::OP_AND8, sm83alu_pkg::OP_OR8, sm83alu_pkg::OP_XOR8: begin
        if (req.func == sm83alu_pkg::OP_AND8) begin
          r8 = a & b;
        end else if (req.func == sm83alu_pkg::OP_OR8) begin
          r8 = a | b;
        end else begin
          r8 = a ^ b;
        end
        rsp.value_out = {8'h00, r8};
        rsp.zero_out = (r8 == 8'h00);
        rsp.subtract_out = 1'b0;
        rsp.half_out = (req.func == sm83alu_pkg::OP_AND8);
        rsp.carry_out = 1'b0;
      end
      sm83alu_pkg::OP_ADD16: begin
        rsp.value_out = add17[15:0];
        rsp.subtract_out = 1'b0;
        rsp.half_out = addh13[12];
        rsp.carry_out = add17[16];
      end
      sm83alu_pkg::OP_INC16: begin
        rsp.value_out = x + 16'd1;
      end
      sm83alu_pkg::OP_DEC16: begin
        rsp.value_out = x - 16'd1;
      end
      sm83alu_pkg::OP_ADDSP: begin
        rsp.value_out = sp_sum;
        rsp.zero_out = 1'b0;
        rsp.subtract_out = 1'b0;
        rsp.half_out = sph5[4];
        rsp.carry_out = spc9[8];
      end
      sm83alu_pkg::OP_RLCA, sm83alu_pkg::OP_RLC: begin
        r8 = {a[6:0], a[7]};
        rsp.value_out = {8'h00, r8};
        rsp.zero_out = (req.func == sm83alu_pkg::OP_RLC) && (r8 == 8'h00);
        rsp.subtract_out = 1'b0;
        rsp.half_out = 1'b0;
        rsp.carry_out = a[7];
      end
      sm83alu_pkg::OP_RRCA, sm83alu_pkg::OP_RRC: begin
        r8 = {a[0], a[7:1]};
        rsp.value_out = {8'h00, r8};
        rsp.zero_out = (req.func == sm83alu_pkg::OP_RRC) && (r8 == 8'h00);
        rsp.subtract_out = 1'b0;
        rsp.half_out = 1'b0;
        rsp.carry_out = a[0];
      end
      sm83alu_pkg::OP_RLA, sm83alu_pkg::OP_RL: begin
        r8 = {a[6:0], cin};
        rsp.value_out = {8'h00, r8};
        rsp.zero_out = (req.func == sm83alu_pkg::OP_RL) && (r8 == 8'h00);
        rsp.subtract_out = 1'b0;
        rsp.half_out = 1'b0;
        rsp.carry_out = a[7];
      end
      sm83alu_pkg::OP_RRA, sm83alu_pkg::OP_RR: begin
        r8 = {cin, a[7:1]};
        rsp.value_out = {8'h00, r8};
        rsp.zero_out = (req.func == sm83alu_pkg::OP_RR) && (r8 == 8'h00);
        rsp.subtract_out = 1'b0;
        rsp.half_out = 1'b0;
        rsp.carry_out = a[0];
      end
      sm83alu_pkg::OP_SLA: begin
        r8 = {a[6:0], 1'b0};
        rsp.value_out = {8'h00, r8};
        rsp.zero_out = (r8 == 8'h00);
        rsp.subtract_out = 1'b0;
        rsp.half_out = 1'b0;
        rsp.carry_out = a[7];
      end
      sm83alu_pkg::OP_SRA, sm83alu_pkg::OP_SRL: begin
        r8 = {(req.func == sm83alu_pkg::OP_SRA) & a[7], a[7:1]};
        rsp.value_out = {8'h00, r8};
        rsp.zero_out = (r8 == 8'h00);
        rsp.subtract_out = 1'b0;
        rsp.half_out = 1'b0;
        rsp.carry_out = a[0];
      end
      sm83alu_pkg::OP_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        rsp.value_out = {8'h00, r8};
        rsp.zero_out = (r8 == 8'h00);
        rsp.subtract_out = 1'b0;
        rsp.half_out = 1'b0;
        rsp.carry_out = 1'b0;
      end
      sm83alu_pkg::OP_BIT: begin
        rsp.zero_out = ((a & bit_mask) == 8'h00);
        rsp.subtract_out = 1'b0;
        rsp.half_out = 1'b1;
      end
      sm83alu_pkg::OP_RES: begin
        rsp.value_out = {8'h00, a & ~bit_mask};
      end
      sm83alu_pkg::OP_SET: begin
        rsp.value_out = {8'h00, a | bit_mask};
      end
      sm83alu_pkg::OP_DAA: begin
        if (req.subtract_in) begin
          r8 = daa_s2;
          rsp.carry_out = cin;
        end else begin
          r8 = daa_hi[7:0];
          rsp.carry_out = cin | daa_hi[8];
        end
        rsp.value_out = {8'h00, r8};
        rsp.zero_out = (r8 == 8'h00);
        rsp.half_out = 1'b0;
      end
      sm83alu_pkg::OP_CPL: begin
        rsp.value_out = {8'h00, ~a};
        rsp.subtract_out = 1'b1;
        rsp.half_out = 1'b1;
      end
      sm83alu_pkg::OP_CCF, sm83alu_pkg::OP_SCF: begin
        rsp.subtract_out = 1'b0;
        rsp.half_out = 1'b0;
        rsp.carry_out = (req.func == sm83alu_pkg::OP_SCF) | ~cin;
      end
      default: begin
        rsp.value_out = x;
      end
    endcase
  end

endmodule
